[hdl/cpx_pkg.sv]
// Shared constants and types for the convex polygon extreme point block.
`timescale 1ns / 1ps

package cpx_pkg;

  // Defaults for the top level parameters.
  localparam int MAX_VERTICES_DEF = 1024;
  localparam int COORD_WIDTH_DEF  = 16;

  // Fixed field widths of the ports.
  localparam int IN_COORD_W = 16;
  localparam int INDEX_W    = 10;
  localparam int COUNT_W    = 11;

  // Configuration port.
  localparam int APB_DATA_W = 32;
  localparam int PADDR_W    = 3;
  localparam logic [PADDR_W-3:0] REG_VERTEX_COUNT = 1'b0;
  localparam logic [COUNT_W-1:0] VERTEX_COUNT_RST = 11'd3;
  localparam logic [COUNT_W-1:0] MIN_VERTICES     = 11'd3;

  // Operation codes of an input transaction.
  localparam logic OP_WRITE = 1'b0;
  localparam logic OP_QUERY = 1'b1;

  // Sign of a dot product.
  typedef struct packed {
    logic pos;
    logic neg;
  } sign_t;

endpackage

[hdl/cpx_ram.sv]
// Generic simple dual-port RAM with a registered read.
`timescale 1ns / 1ps

module cpx_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[hdl/cpx_dot.sv]
// Pipelined sign of the query direction dotted with a vertex difference.
`timescale 1ns / 1ps

module cpx_dot #(
  parameter int COORD_WIDTH = cpx_pkg::COORD_WIDTH_DEF
) (
  input  logic                          clk,
  input  logic                          base_load,
  input  logic signed [COORD_WIDTH-1:0] rd_x,
  input  logic signed [COORD_WIDTH-1:0] rd_y,
  input  logic signed [COORD_WIDTH-1:0] dir_x,
  input  logic signed [COORD_WIDTH-1:0] dir_y,
  output cpx_pkg::sign_t                sgn
);

  localparam int DW = COORD_WIDTH + 1;
  localparam int PW = 2 * COORD_WIDTH + 1;
  localparam int SW = PW + 1;

  logic signed [COORD_WIDTH-1:0] base_x;
  logic signed [COORD_WIDTH-1:0] base_y;
  logic signed [DW-1:0]          ex;
  logic signed [DW-1:0]          ey;
  logic signed [PW-1:0]          px;
  logic signed [PW-1:0]          py;
  logic signed [SW-1:0]          sum;

  // The base vertex is latched once per round; every later read is taken
  // relative to it, one vertex per cycle.
  always_ff @(posedge clk) begin
    if (base_load) begin
      base_x <= rd_x;
      base_y <= rd_y;
    end
    ex <= $signed({rd_x[COORD_WIDTH-1], rd_x}) - $signed({base_x[COORD_WIDTH-1], base_x});
    ey <= $signed({rd_y[COORD_WIDTH-1], rd_y}) - $signed({base_y[COORD_WIDTH-1], base_y});
    px <= ex * dir_x;
    py <= ey * dir_y;
  end

  assign sum     = $signed({px[PW-1], px}) + $signed({py[PW-1], py});
  assign sgn.neg = sum[SW-1];
  assign sgn.pos = !sum[SW-1] && (sum != '0);

endmodule

[hdl/convex_polygon_extreme_point_top.sv]
// Extreme vertex of a convex polygon along a query direction, by binary search.
// A vertex write gives no result. A query runs one opening round and
// then one round per halving of the index interval, each making four reads of the single
// vertex memory port that feed the dot product pipeline.
// Reset sets vertex_count to 3; the vertex memory is not cleared and needs no clearing pass.
`timescale 1ns / 1ps

module convex_polygon_extreme_point_top #(
  parameter int MAX_VERTICES = cpx_pkg::MAX_VERTICES_DEF,
  parameter int COORD_WIDTH  = cpx_pkg::COORD_WIDTH_DEF
) (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   psel,
  input  logic                                   penable,
  input  logic                                   pwrite,
  input  logic [cpx_pkg::PADDR_W-1:0]            paddr,
  input  logic [cpx_pkg::APB_DATA_W-1:0]         pwdata,
  output logic [cpx_pkg::APB_DATA_W-1:0]         prdata,
  output logic                                   pready,
  input  logic                                   in_valid,
  output logic                                   in_ready,
  input  logic                                   operation,
  input  logic [cpx_pkg::INDEX_W-1:0]            vertex_index,
  input  logic signed [cpx_pkg::IN_COORD_W-1:0]  vertex_x,
  input  logic signed [cpx_pkg::IN_COORD_W-1:0]  vertex_y,
  input  logic signed [cpx_pkg::IN_COORD_W-1:0]  dir_x,
  input  logic signed [cpx_pkg::IN_COORD_W-1:0]  dir_y,
  output logic                                   out_valid,
  input  logic                                   out_ready,
  output logic [cpx_pkg::INDEX_W-1:0]            extreme_index
);

  localparam int AW = $clog2(MAX_VERTICES);
  localparam int NW = $clog2(MAX_VERTICES + 1);
  localparam int VW = 2 * COORD_WIDTH;

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_RUN  = 1'b1;

  localparam logic [2:0] STEP_READ_MID  = 3'd0;
  localparam logic [2:0] STEP_READ_NEXT = 3'd1;
  localparam logic [2:0] STEP_READ_PREV = 3'd2;
  localparam logic [2:0] STEP_READ_LO   = 3'd3;
  localparam logic [2:0] STEP_SIGN_NEXT = 3'd4;
  localparam logic [2:0] STEP_SIGN_PREV = 3'd5;
  localparam logic [2:0] STEP_SIGN_LO   = 3'd6;
  localparam logic [2:0] STEP_DECIDE    = 3'd7;

  logic                          state;
  logic [2:0]                    step;
  logic [cpx_pkg::COUNT_W-1:0]   vertex_count;

  logic [NW-1:0]                 n;
  logic [NW-1:0]                 lo;
  logic [NW-1:0]                 hi;
  logic [AW-1:0]                 mid;
  logic                          first;
  logic                          up_lo_pos;
  cpx_pkg::sign_t                up_mid;
  logic                          prev_pos;
  cpx_pkg::sign_t                lo_sgn;
  logic signed [COORD_WIDTH-1:0] qdx;
  logic signed [COORD_WIDTH-1:0] qdy;

  logic [31:0]                   n_wide;
  logic [31:0]                   wr_idx_wide;
  logic [31:0]                   wx_wide;
  logic [31:0]                   wy_wide;
  logic [31:0]                   dx_wide;
  logic [31:0]                   dy_wide;
  logic [31:0]                   mid_wide;
  logic [NW:0]                   mid_sum;
  logic [AW-1:0]                 mid_sel;
  logic [NW-1:0]                 mid_inc;
  logic [NW-1:0]                 n_dec;
  logic [NW-1:0]                 span;
  logic [AW-1:0]                 next_addr;
  logic [AW-1:0]                 prev_addr;
  logic [AW-1:0]                 raddr;
  logic [VW-1:0]                 rdata;
  logic                          ram_we;
  logic                          in_acc;
  logic                          cfg_wr;
  logic                          found;
  logic                          finish;
  logic                          go_hi;
  logic                          can_emit;
  logic                          emit;
  cpx_pkg::sign_t                sgn;

  assign in_acc = in_valid && in_ready;
  assign in_ready = (state == ST_IDLE);
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite
                  && (paddr[cpx_pkg::PADDR_W-1:2] == cpx_pkg::REG_VERTEX_COUNT);

  always_comb begin
    prdata = '0;
    if (paddr[cpx_pkg::PADDR_W-1:2] == cpx_pkg::REG_VERTEX_COUNT) begin
      prdata[cpx_pkg::COUNT_W-1:0] = vertex_count;
    end
  end

  // Vertex count clamped to the supported range.
  always_comb begin
    if (vertex_count < cpx_pkg::MIN_VERTICES) begin
      n_wide = 32'(cpx_pkg::MIN_VERTICES);
    end else if (32'(vertex_count) > 32'(MAX_VERTICES)) begin
      n_wide = 32'(MAX_VERTICES);
    end else begin
      n_wide = 32'(vertex_count);
    end
  end

  // Coordinates keep the low COORD_WIDTH bits of the 16-bit field.
  assign wr_idx_wide = 32'(vertex_index);
  assign wx_wide     = 32'(unsigned'(vertex_x));
  assign wy_wide     = 32'(unsigned'(vertex_y));
  assign dx_wide     = 32'(unsigned'(dir_x));
  assign dy_wide     = 32'(unsigned'(dir_y));
  assign ram_we      = in_acc && (operation == cpx_pkg::OP_WRITE)
                       && (wr_idx_wide < 32'(MAX_VERTICES));

  // Ring neighbors of the probe; the vertex before index 0 is the last one.
  assign mid_sum   = {1'b0, lo} + {1'b0, hi};
  assign mid_sel   = first ? '0 : mid_sum[AW:1];
  assign mid_inc   = NW'(mid) + NW'(1);
  assign n_dec     = n - NW'(1);
  assign next_addr = (mid_inc == n) ? '0 : mid_inc[AW-1:0];
  assign prev_addr = (mid == '0) ? n_dec[AW-1:0] : mid - AW'(1);

  always_comb begin
    unique case (step)
      STEP_READ_MID:  raddr = mid_sel;
      STEP_READ_NEXT: raddr = next_addr;
      STEP_READ_PREV: raddr = prev_addr;
      STEP_READ_LO:   raddr = lo[AW-1:0];
      default:        raddr = mid;
    endcase
  end

  cpx_ram #(
    .WIDTH (VW),
    .DEPTH (MAX_VERTICES)
  ) u_vertex_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (wr_idx_wide[AW-1:0]),
    .wdata ({wx_wide[COORD_WIDTH-1:0], wy_wide[COORD_WIDTH-1:0]}),
    .raddr (raddr),
    .rdata (rdata)
  );

  cpx_dot #(
    .COORD_WIDTH (COORD_WIDTH)
  ) u_dot (
    .clk       (clk),
    .base_load ((state == ST_RUN) && (step == STEP_READ_NEXT)),
    .rd_x      (rdata[VW-1:COORD_WIDTH]),
    .rd_y      (rdata[COORD_WIDTH-1:0]),
    .dir_x     (qdx),
    .dir_y     (qdy),
    .sgn       (sgn)
  );

  // The probe is extreme when the next edge does not climb and the previous
  // vertex is not above it. The opening round probes vertex 0 only.
  assign span     = hi - lo;
  assign found    = !up_mid.pos && !prev_pos;
  assign finish   = found || (!first && (span <= NW'(1)));
  assign go_hi    = up_lo_pos ? (up_mid.neg || lo_sgn.pos) : (!up_mid.pos && lo_sgn.neg);
  assign can_emit = !out_valid || out_ready;
  assign emit     = (state == ST_RUN) && (step == STEP_DECIDE) && finish && can_emit;
  assign mid_wide = 32'(mid);

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      step         <= STEP_READ_MID;
      out_valid    <= 1'b0;
      vertex_count <= cpx_pkg::VERTEX_COUNT_RST;
    end else begin
      if (cfg_wr) begin
        vertex_count <= pwdata[cpx_pkg::COUNT_W-1:0];
      end
      if (emit) begin
        out_valid <= 1'b1;
      end else if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (in_acc && (operation == cpx_pkg::OP_QUERY)) begin
            state <= ST_RUN;
            step  <= STEP_READ_MID;
          end
        end
        ST_RUN: begin
          if (step != STEP_DECIDE) begin
            step <= step + 3'd1;
          end else if (!finish) begin
            step <= STEP_READ_MID;
          end else if (can_emit) begin
            state <= ST_IDLE;
            step  <= STEP_READ_MID;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc && (operation == cpx_pkg::OP_QUERY)) begin
      n     <= n_wide[NW-1:0];
      lo    <= '0;
      hi    <= n_wide[NW-1:0];
      first <= 1'b1;
      qdx   <= dx_wide[COORD_WIDTH-1:0];
      qdy   <= dy_wide[COORD_WIDTH-1:0];
    end
    if (state == ST_RUN) begin
      unique case (step)
        STEP_READ_MID:  mid      <= mid_sel;
        STEP_SIGN_NEXT: up_mid   <= sgn;
        STEP_SIGN_PREV: prev_pos <= sgn.pos;
        STEP_SIGN_LO:   lo_sgn   <= sgn;
        STEP_DECIDE: begin
          if (finish) begin
            if (can_emit) begin
              extreme_index <= mid_wide[cpx_pkg::INDEX_W-1:0];
            end
          end else if (first) begin
            first     <= 1'b0;
            up_lo_pos <= up_mid.pos;
          end else if (go_hi) begin
            hi <= NW'(mid);
          end else begin
            lo        <= NW'(mid);
            up_lo_pos <= up_mid.pos;
          end
        end
        default: begin
        end
      endcase
    end
  end

endmodule
